>>> hw/rtl/srsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsl_pkg
// Shared types and constants for the stepper rate / slew limiter.
// ----------------------------------------------------------------------------
package srsl_pkg;

  localparam int CMD_W      = 16;
  localparam int CODE_W     = 3;
  localparam int RATE_W     = 24;
  localparam int ACCEL_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CODE_W-1:0]  MICRO_MAX_CODE = 3'd5;
  localparam logic [RATE_W-1:0]  RATE_RESET     = 24'd1000000;
  localparam logic [ACCEL_W-1:0] ACCEL_RESET    = 15'd164;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INVERT_LEFT  = 3'd0,
    REG_INVERT_RIGHT = 3'd1,
    REG_SWAP_SIDES   = 3'd2,
    REG_MOTORS_EN    = 3'd3,
    REG_MAX_RATE     = 3'd4,
    REG_MAX_ACCEL    = 3'd5
  } cfg_reg_t;

  // Control from top / merge into one lane.
  typedef struct packed {
    logic start;
    logic clr;
    logic bad;
    logic skip;
    logic take;
  } lane_ctl_t;

  // Status from one lane.
  typedef struct packed {
    logic idle;
    logic done;
    logic neg;
  } lane_sts_t;

endpackage

>>> hw/rtl/srsl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsl_in_if
// Command word channel: two speed commands, microstep code, slew bypass.
// ----------------------------------------------------------------------------
interface srsl_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [srsl_pkg::CMD_W-1:0]   left_cmd;
  logic signed [srsl_pkg::CMD_W-1:0]   right_cmd;
  logic        [srsl_pkg::CODE_W-1:0]  microstep_log2;
  logic                                skip_slew;

  modport source (output valid, left_cmd, right_cmd, microstep_log2, skip_slew,
                  input ready);
  modport sink   (input valid, left_cmd, right_cmd, microstep_log2, skip_slew,
                  output ready);
endinterface

>>> hw/rtl/srsl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsl_out_if
// Result word channel: drive enable, directions and step periods.
// ----------------------------------------------------------------------------
interface srsl_out_if #(
  parameter int PERIOD_WIDTH = 32
);
  logic                               valid;
  logic                               ready;
  logic                               drive_on;
  logic [srsl_pkg::CODE_W-1:0]        microstep_out;
  logic                               dir_left;
  logic                               dir_right;
  logic [PERIOD_WIDTH-1:0]            period_left;
  logic [PERIOD_WIDTH-1:0]            period_right;
  logic                               bad_microstep;

  modport source (output valid, drive_on, microstep_out, dir_left, dir_right,
                  period_left, period_right, bad_microstep, input ready);
  modport sink   (input valid, drive_on, microstep_out, dir_left, dir_right,
                  period_left, period_right, bad_microstep, output ready);
endinterface

>>> hw/rtl/srsl_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsl_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface srsl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [srsl_pkg::CFG_IDX_W-1:0]      index;
  logic [srsl_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/srsl_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsl_lane
// One side: held speed with slew limit, then bit-serial period divider.
// ----------------------------------------------------------------------------
module srsl_lane #(
  parameter int SPEED_FRAC_BITS = 14,
  parameter int PERIOD_WIDTH    = 32,
  localparam int HELD_W = (SPEED_FRAC_BITS >= 15) ? 17 : SPEED_FRAC_BITS + 2,
  localparam int NUM_W  = srsl_pkg::RATE_W + SPEED_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  srsl_pkg::lane_ctl_t                ctl,
  input  logic signed [HELD_W-1:0]           target,
  input  logic [srsl_pkg::ACCEL_W-1:0]       max_accel,
  input  logic [NUM_W-1:0]                   numer,
  output srsl_pkg::lane_sts_t                sts,
  output logic [PERIOD_WIDTH-1:0]            period
);
  import srsl_pkg::*;

  localparam int MAG_W = HELD_W - 1;
  localparam int SW    = ((HELD_W > ACCEL_W + 1) ? HELD_W : ACCEL_W + 1) + 1;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int QX_W  = (NUM_W > PERIOD_WIDTH) ? NUM_W : PERIOD_WIDTH;
  localparam int CAP   = (SPEED_FRAC_BITS >= 15) ? 32768 : (1 << SPEED_FRAC_BITS);
  localparam logic signed [HELD_W-1:0] HELD_MAX = HELD_W'(CAP);
  localparam logic signed [HELD_W-1:0] HELD_MIN = -HELD_MAX;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SLEW = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } lane_state_t;

  lane_state_t               state_r, state_nxt;
  logic signed [HELD_W-1:0]  held_r, held_nxt;
  logic signed [HELD_W-1:0]  tgt_r;
  logic                      skip_r;
  logic                      bad_r;
  logic [MAG_W-1:0]          mag_r;
  logic                      zero_r;
  logic [NUM_W-1:0]          quo_r;
  logic [MAG_W-1:0]          rem_r;
  logic [CNT_W-1:0]          cnt_r;

  logic signed [SW-1:0]      held_x, acc_x, hi, lo, tgt_x;
  logic signed [HELD_W-1:0]  slewed;
  logic signed [HELD_W-1:0]  held_abs;
  logic [MAG_W:0]            rem_sh, diff;
  logic                      ge;
  logic [QX_W-1:0]           q_ext, pmax_ext;

  // slew limit: move toward target by at most max_accel
  always_comb begin
    held_x = SW'(held_r);
    tgt_x  = SW'(tgt_r);
    acc_x  = SW'($signed({1'b0, max_accel}));
    hi     = held_x + acc_x;
    lo     = held_x - acc_x;
    if (tgt_x > hi) begin
      slewed = hi[HELD_W-1:0];
    end else if (tgt_x < lo) begin
      slewed = lo[HELD_W-1:0];
    end else begin
      slewed = tgt_r;
    end
  end

  assign held_abs = held_r[HELD_W-1] ? -held_r : held_r;

  // restoring divide step
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, mag_r});
  assign diff   = rem_sh - {1'b0, mag_r};

  always_comb begin
    held_nxt = held_r;
    if (ctl.clr) begin
      held_nxt = '0;
    end else if ((state_r == ST_SLEW) && !bad_r) begin
      held_nxt = skip_r ? tgt_r : slewed;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (ctl.start) state_nxt = ST_SLEW;
      ST_SLEW: state_nxt = bad_r ? ST_DONE : ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == '0) state_nxt = ST_DONE;
      ST_DONE: if (ctl.take) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r  <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          tgt_r  <= target;
          skip_r <= ctl.skip;
          bad_r  <= ctl.bad;
          zero_r <= 1'b1;
        end
      end
      ST_LOAD: begin
        mag_r  <= held_abs[MAG_W-1:0];
        zero_r <= (held_r == '0);
        quo_r  <= numer;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(NUM_W - 1);
      end
      ST_DIV: begin
        quo_r <= {quo_r[NUM_W-2:0], ge};
        rem_r <= ge ? diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign q_ext    = QX_W'(quo_r);
  assign pmax_ext = QX_W'({PERIOD_WIDTH{1'b1}});

  always_comb begin
    if (zero_r) begin
      period = '0;
    end else if (q_ext > pmax_ext) begin
      period = '1;
    end else begin
      period = q_ext[PERIOD_WIDTH-1:0];
    end
  end

  assign sts.idle = (state_r == ST_IDLE);
  assign sts.done = (state_r == ST_DONE);
  assign sts.neg  = held_r[HELD_W-1];

`ifndef SYNTHESIS
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r != '0) |=> (state_r == ST_DIV))
    else $error("divider left its loop early");

  a_bad_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SLEW && bad_r && !ctl.clr) |=> $stable(held_r))
    else $error("rejected word changed held speed");

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r <= HELD_MAX) && (held_r >= HELD_MIN))
    else $error("held speed beyond full scale");
`endif

endmodule

>>> hw/rtl/srsl_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsl_merge
// Joins both lane results into one output word register.
// ----------------------------------------------------------------------------
module srsl_merge #(
  parameter int PERIOD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srsl_pkg::lane_sts_t           sts_l,
  input  srsl_pkg::lane_sts_t           sts_r,
  input  logic [PERIOD_WIDTH-1:0]       period_l,
  input  logic [PERIOD_WIDTH-1:0]       period_r,
  input  logic [srsl_pkg::CODE_W-1:0]   code,
  input  logic                          bad,
  input  logic                          drive_on,
  output logic                          take,
  srsl_out_if.source                    out_word
);
  import srsl_pkg::*;

  logic                     out_valid_r;
  logic                     drive_r;
  logic [CODE_W-1:0]        code_r;
  logic                     dir_l_r, dir_r_r;
  logic [PERIOD_WIDTH-1:0]  per_l_r, per_r_r;
  logic                     bad_r;

  assign take = sts_l.done & sts_r.done & (~out_valid_r | out_word.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // bad code: every field but the flag reads zero
  always_ff @(posedge clk) begin
    if (take) begin
      bad_r   <= bad;
      drive_r <= bad ? 1'b0 : drive_on;
      code_r  <= bad ? '0 : code;
      dir_l_r <= bad ? 1'b0 : sts_l.neg;
      dir_r_r <= bad ? 1'b0 : sts_r.neg;
      per_l_r <= bad ? '0 : period_l;
      per_r_r <= bad ? '0 : period_r;
    end
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.drive_on      = drive_r;
  assign out_word.microstep_out = code_r;
  assign out_word.dir_left      = dir_l_r;
  assign out_word.dir_right     = dir_r_r;
  assign out_word.period_left   = per_l_r;
  assign out_word.period_right  = per_r_r;
  assign out_word.bad_microstep = bad_r;

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (per_l_r == '0 && per_r_r == '0 && !drive_r))
    else $error("rejected word carries nonzero fields");
`endif

endmodule

>>> hw/rtl/stepper_rate_slew_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_rate_slew_limiter
// Speed commands to step periods, with clip, invert, swap and slew limit.
// ----------------------------------------------------------------------------
// Each lane takes a word through slew, load and divide states; the merge stage then
//   registers both lane results into the output word.
// Words are taken one at a time, paced by the one-bit-per-cycle restoring divider
//   in each lane (24+SPEED_FRAC_BITS quotient bits).
// The next word is taken in the cycle its predecessor's result appears.
// Reset: synchronous, active low; held speeds zero, registers to their defaults.
// ----------------------------------------------------------------------------
module stepper_rate_slew_limiter #(
  parameter int SPEED_FRAC_BITS = 14,
  parameter int PERIOD_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  srsl_in_if.sink     in_word,
  srsl_out_if.source  out_word,
  srsl_cfg_if.sink    cfg_wr
);
  import srsl_pkg::*;

  // held speed width: full scale plus sign, or 17 bits once full scale
  // exceeds what a 16-bit command can reach (negated -32768)
  localparam int HELD_W = (SPEED_FRAC_BITS >= 15) ? 17 : SPEED_FRAC_BITS + 2;
  localparam int NUM_W  = RATE_W + SPEED_FRAC_BITS;
  // clip math wide enough for both the sign-extended command and full scale
  localparam int XW     = (SPEED_FRAC_BITS + 2 > CMD_W + 1) ? SPEED_FRAC_BITS + 2
                                                            : CMD_W + 1;
  localparam logic signed [XW-1:0] FULL_X     = XW'(1) << SPEED_FRAC_BITS;
  localparam logic signed [XW-1:0] NEG_FULL_X = -FULL_X;

  // configuration registers
  logic               inv_l_r, inv_r_r, swap_r, motors_en_r;
  logic [RATE_W-1:0]  max_rate_r;
  logic [ACCEL_W-1:0] max_accel_r;

  // per-word context kept for the merge stage
  logic [CODE_W-1:0]  code_r;
  logic               bad_r;

  logic               cfg_acc, in_acc, in_bad, clr;
  logic signed [XW-1:0] cl_l, cl_r, sd_l, sd_r;
  logic signed [HELD_W-1:0] tgt_l, tgt_r;
  logic [NUM_W-1:0]   numer;

  lane_ctl_t          ctl_l, ctl_r;
  lane_sts_t          sts_l, sts_r;
  logic [PERIOD_WIDTH-1:0] per_l, per_r;
  logic               take;

  // config port: always ready; the host must write only while no word is in flight (not enforced here)
  assign cfg_wr.ready = 1'b1;
  assign cfg_acc      = cfg_wr.valid & cfg_wr.ready;
  assign clr = cfg_acc && (cfg_wr.index == REG_MOTORS_EN) && !cfg_wr.data[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_l_r     <= 1'b0;
      inv_r_r     <= 1'b0;
      swap_r      <= 1'b0;
      motors_en_r <= 1'b0;
      max_rate_r  <= RATE_RESET;
      max_accel_r <= ACCEL_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_wr.index)
        REG_INVERT_LEFT:  inv_l_r     <= cfg_wr.data[0];
        REG_INVERT_RIGHT: inv_r_r     <= cfg_wr.data[0];
        REG_SWAP_SIDES:   swap_r      <= cfg_wr.data[0];
        REG_MOTORS_EN:    motors_en_r <= cfg_wr.data[0];
        REG_MAX_RATE:     max_rate_r  <= cfg_wr.data[RATE_W-1:0];
        REG_MAX_ACCEL:    max_accel_r <= cfg_wr.data[ACCEL_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // one word in flight: take a new one once both lanes are back in idle
  assign in_word.ready = sts_l.idle & sts_r.idle;
  assign in_acc        = in_word.valid & in_word.ready;
  assign in_bad        = (in_word.microstep_log2 > MICRO_MAX_CODE);

  // clip to +/- full scale, invert, then optional swap
  always_comb begin
    cl_l = XW'(in_word.left_cmd);
    cl_r = XW'(in_word.right_cmd);
    if (cl_l > FULL_X) begin
      cl_l = FULL_X;
    end else if (cl_l < NEG_FULL_X) begin
      cl_l = NEG_FULL_X;
    end
    if (cl_r > FULL_X) begin
      cl_r = FULL_X;
    end else if (cl_r < NEG_FULL_X) begin
      cl_r = NEG_FULL_X;
    end
    if (inv_l_r) cl_l = -cl_l;
    if (inv_r_r) cl_r = -cl_r;
    sd_l = swap_r ? cl_r : cl_l;
    sd_r = swap_r ? cl_l : cl_r;
  end

  assign tgt_l = sd_l[HELD_W-1:0];
  assign tgt_r = sd_r[HELD_W-1:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      code_r <= in_word.microstep_log2;
      bad_r  <= in_bad;
    end
  end

  // shared numerator: (max_rate >> code) << frac bits
  assign numer = NUM_W'(max_rate_r >> code_r) << SPEED_FRAC_BITS;

  always_comb begin
    ctl_l.start = in_acc;
    ctl_l.clr   = clr;
    ctl_l.bad   = in_bad;
    ctl_l.skip  = in_word.skip_slew;
    ctl_l.take  = take;
    ctl_r       = ctl_l;
  end

  srsl_lane #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
    .PERIOD_WIDTH    (PERIOD_WIDTH)
  ) u_lane_l (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_l),
    .target    (tgt_l),
    .max_accel (max_accel_r),
    .numer     (numer),
    .sts       (sts_l),
    .period    (per_l)
  );

  srsl_lane #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
    .PERIOD_WIDTH    (PERIOD_WIDTH)
  ) u_lane_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_r),
    .target    (tgt_r),
    .max_accel (max_accel_r),
    .numer     (numer),
    .sts       (sts_r),
    .period    (per_r)
  );

  srsl_merge #(
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts_l    (sts_l),
    .sts_r    (sts_r),
    .period_l (per_l),
    .period_r (per_r),
    .code     (code_r),
    .bad      (bad_r),
    .drive_on (motors_en_r),
    .take     (take),
    .out_word (out_word)
  );

endmodule
